### design/bbc_pkg.sv
// Shared types, constants and decode functions for the bracket balance checker.
package bbc_pkg;

  // Default sizes
  localparam int STACK_DEPTH = 64;
  localparam int POS_WIDTH   = 16;
  localparam int OUT_POS_W   = 16;
  localparam int OUT_POS_MAX = 65535;

  // Character codes
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Bracket kinds
  typedef enum logic [1:0] {
    KIND_PAREN  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Verdict codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_OPEN   = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_UNCLOSED  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // Stack operation sent down the cell chain
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  function automatic kind_t open_kind(input logic [7:0] c);
    kind_t k;
    k = KIND_NONE;
    if (c == CH_LPAREN)  k = KIND_PAREN;
    if (c == CH_LSQUARE) k = KIND_SQUARE;
    if (c == CH_LCURLY)  k = KIND_CURLY;
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [7:0] c);
    kind_t k;
    k = KIND_NONE;
    if (c == CH_RPAREN)  k = KIND_PAREN;
    if (c == CH_RSQUARE) k = KIND_SQUARE;
    if (c == CH_RCURLY)  k = KIND_CURLY;
    return k;
  endfunction

endpackage

### design/bbc_if.sv
// Valid/ready channel interfaces for text bytes and verdicts.
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] err_row;
  logic [15:0] err_col;

  modport source (output valid, output status, output err_row, output err_col, input ready);
  modport sink   (input valid, input status, input err_row, input err_col, output ready);
endinterface

### design/bbc_cell.sv
// One stack cell: holds an opener's kind and position, shifts with its neighbors.
module bbc_cell #(
  parameter int POS_W = bbc_pkg::POS_WIDTH
) (
  input  logic               clk,
  input  bbc_pkg::op_t       op,
  input  bbc_pkg::kind_t     up_kind,
  input  logic [POS_W-1:0]   up_row,
  input  logic [POS_W-1:0]   up_col,
  input  bbc_pkg::kind_t     dn_kind,
  input  logic [POS_W-1:0]   dn_row,
  input  logic [POS_W-1:0]   dn_col,
  output bbc_pkg::kind_t     kind_r,
  output logic [POS_W-1:0]   row_r,
  output logic [POS_W-1:0]   col_r
);

  // Push takes the entry from above, pop takes the one from below
  always_ff @(posedge clk) begin
    unique case (op)
      bbc_pkg::OP_PUSH: begin
        kind_r <= up_kind;
        row_r  <= up_row;
        col_r  <= up_col;
      end
      bbc_pkg::OP_POP: begin
        kind_r <= dn_kind;
        row_r  <= dn_row;
        col_r  <= dn_col;
      end
      default: begin
        kind_r <= kind_r;
        row_r  <= row_r;
        col_r  <= col_r;
      end
    endcase
  end

endmodule

### design/bbc_stack.sv
// Shift-register stack built as a chain of cells; cell 0 is the top.
module bbc_stack #(
  parameter int DEPTH = bbc_pkg::STACK_DEPTH,
  parameter int POS_W = bbc_pkg::POS_WIDTH
) (
  input  logic             clk,
  input  bbc_pkg::op_t     op,
  input  bbc_pkg::kind_t   push_kind,
  input  logic [POS_W-1:0] push_row,
  input  logic [POS_W-1:0] push_col,
  output bbc_pkg::kind_t   top_kind,
  output logic [POS_W-1:0] top_row,
  output logic [POS_W-1:0] top_col,
  output logic [POS_W-1:0] sec_row,
  output logic [POS_W-1:0] sec_col
);

  bbc_pkg::kind_t   kind_q [DEPTH];
  logic [POS_W-1:0] row_q  [DEPTH];
  logic [POS_W-1:0] col_q  [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      bbc_pkg::kind_t   up_k, dn_k;
      logic [POS_W-1:0] up_rw, up_cl, dn_rw, dn_cl;

      // Neighbor wiring; the ends see the new entry and their own contents
      if (i == 0) begin : g_top
        assign up_k  = push_kind;
        assign up_rw = push_row;
        assign up_cl = push_col;
      end else begin : g_mid_up
        assign up_k  = kind_q[i-1];
        assign up_rw = row_q[i-1];
        assign up_cl = col_q[i-1];
      end
      if (i == DEPTH-1) begin : g_bottom
        assign dn_k  = kind_q[i];
        assign dn_rw = row_q[i];
        assign dn_cl = col_q[i];
      end else begin : g_mid_dn
        assign dn_k  = kind_q[i+1];
        assign dn_rw = row_q[i+1];
        assign dn_cl = col_q[i+1];
      end

      bbc_cell #(.POS_W(POS_W)) u_cell (
        .clk     (clk),
        .op      (op),
        .up_kind (up_k),
        .up_row  (up_rw),
        .up_col  (up_cl),
        .dn_kind (dn_k),
        .dn_row  (dn_rw),
        .dn_col  (dn_cl),
        .kind_r  (kind_q[i]),
        .row_r   (row_q[i]),
        .col_r   (col_q[i])
      );
    end
  endgenerate

  assign top_kind = kind_q[0];
  assign top_row  = row_q[0];
  assign top_col  = col_q[0];
  assign sec_row  = row_q[1];
  assign sec_col  = col_q[1];

endmodule

### design/bracket_balance_checker.sv
// Top level of the bracket balance checker: position tracking, error latch, verdict output.
//
// Takes one text byte per clock cycle, back to back, with no gaps between texts.
// Openers are kept in a chain of STACK_DEPTH cells that all shift by one place
// in the same cycle on a push or pop, so the work for a byte does not grow with
// the nesting depth. The verdict for a text is registered in the output register,
// or in the skid entry while the output is held. A two-entry output buffer lets input
// bytes keep flowing while a verdict waits; input stalls only when both entries
// hold verdicts not yet taken. Row and column counters are POS_WIDTH bits and
// stop at their maximum; reported positions are capped at 65535. No clearing
// pass is needed after reset.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH,
  parameter int POS_WIDTH   = bbc_pkg::POS_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  bbc_in_if.sink       in_ch,
  bbc_out_if.source    out_ch
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

  // Control state
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [POS_WIDTH-1:0]  row_r, row_nxt;
  logic [POS_WIDTH-1:0]  col_r, col_nxt;
  bbc_pkg::status_t      err_r, err_nxt;
  logic [POS_WIDTH-1:0]  err_row_r, err_row_nxt;
  logic [POS_WIDTH-1:0]  err_col_r, err_col_nxt;

  // Stack interface
  bbc_pkg::op_t          op;
  bbc_pkg::kind_t        top_kind;
  logic [POS_WIDTH-1:0]  top_row, top_col, sec_row, sec_col;

  // Decode
  logic                  in_fire;
  bbc_pkg::kind_t        ok, ck;
  logic                  active, full, empty;
  logic [POS_WIDTH-1:0]  vr_row, vr_col;
  bbc_pkg::status_t      vr_status;
  logic [15:0]           vr_row_cap, vr_col_cap;
  logic                  res_valid;

  // Output buffer
  logic                  out_valid_r, skid_valid_r;
  logic [2:0]            out_status_r, skid_status_r;
  logic [15:0]           out_row_r, out_col_r, skid_row_r, skid_col_r;
  logic                  out_free;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign ok          = bbc_pkg::open_kind(in_ch.char_code);
  assign ck          = bbc_pkg::close_kind(in_ch.char_code);
  assign active      = in_fire && (err_r == bbc_pkg::ST_OK);
  assign full        = (count_r == CNT_W'(STACK_DEPTH));
  assign empty       = (count_r == '0);
  assign res_valid   = in_fire && in_ch.last;

  bbc_stack #(.DEPTH(STACK_DEPTH), .POS_W(POS_WIDTH)) u_stack (
    .clk       (clk),
    .op        (op),
    .push_kind (ok),
    .push_row  (row_r),
    .push_col  (col_r),
    .top_kind  (top_kind),
    .top_row   (top_row),
    .top_col   (top_col),
    .sec_row   (sec_row),
    .sec_col   (sec_col)
  );

  // Bracket handling and first-error latch
  always_comb begin
    op          = bbc_pkg::OP_HOLD;
    count_nxt   = count_r;
    err_nxt     = err_r;
    err_row_nxt = err_row_r;
    err_col_nxt = err_col_r;
    if (active) begin
      if (ok != bbc_pkg::KIND_NONE) begin
        if (full) begin
          err_nxt     = bbc_pkg::ST_OVERFLOW;
          err_row_nxt = row_r;
          err_col_nxt = col_r;
        end else begin
          op        = bbc_pkg::OP_PUSH;
          count_nxt = count_r + CNT_W'(1);
        end
      end else if (ck != bbc_pkg::KIND_NONE) begin
        if (empty) begin
          err_nxt     = bbc_pkg::ST_NO_OPEN;
          err_row_nxt = row_r;
          err_col_nxt = col_r;
        end else if (top_kind != ck) begin
          err_nxt     = bbc_pkg::ST_MISMATCH;
          err_row_nxt = row_r;
          err_col_nxt = col_r;
        end else begin
          op        = bbc_pkg::OP_POP;
          count_nxt = count_r - CNT_W'(1);
        end
      end
    end
  end

  // Position counters, saturating
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_fire) begin
      if (in_ch.char_code == bbc_pkg::CH_NEWLINE) begin
        row_nxt = (row_r == '1) ? row_r : row_r + POS_ONE;
        col_nxt = POS_ONE;
      end else begin
        col_nxt = (col_r == '1) ? col_r : col_r + POS_ONE;
      end
    end
  end

  // Verdict from the state after this byte; innermost opener after the stack op
  always_comb begin
    vr_status = bbc_pkg::ST_OK;
    vr_row    = '0;
    vr_col    = '0;
    if (err_nxt != bbc_pkg::ST_OK) begin
      vr_status = err_nxt;
      vr_row    = err_row_nxt;
      vr_col    = err_col_nxt;
    end else if (count_nxt != '0) begin
      vr_status = bbc_pkg::ST_UNCLOSED;
      unique case (op)
        bbc_pkg::OP_PUSH: begin
          vr_row = row_r;
          vr_col = col_r;
        end
        bbc_pkg::OP_POP: begin
          vr_row = sec_row;
          vr_col = sec_col;
        end
        default: begin
          vr_row = top_row;
          vr_col = top_col;
        end
      endcase
    end
    vr_row_cap = (32'(vr_row) > 32'(bbc_pkg::OUT_POS_MAX)) ? 16'hFFFF : 16'(vr_row);
    vr_col_cap = (32'(vr_col) > 32'(bbc_pkg::OUT_POS_MAX)) ? 16'hFFFF : 16'(vr_col);
  end

  // Checker state; a verdict returns everything to its start values
  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      count_r   <= '0;
      row_r     <= POS_ONE;
      col_r     <= POS_ONE;
      err_r     <= bbc_pkg::ST_OK;
      err_row_r <= '0;
      err_col_r <= '0;
    end else begin
      count_r   <= count_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      err_r     <= err_nxt;
      err_row_r <= err_row_nxt;
      err_col_r <= err_col_nxt;
    end
  end

  // Two-entry output buffer: output register plus skid entry
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r  <= skid_valid_r || res_valid;
        skid_valid_r <= 1'b0;
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_status_r <= skid_status_r;
        out_row_r    <= skid_row_r;
        out_col_r    <= skid_col_r;
      end else if (res_valid) begin
        out_status_r <= vr_status;
        out_row_r    <= vr_row_cap;
        out_col_r    <= vr_col_cap;
      end
    end else if (res_valid) begin
      skid_status_r <= vr_status;
      skid_row_r    <= vr_row_cap;
      skid_col_r    <= vr_col_cap;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.err_row = out_row_r;
  assign out_ch.err_col = out_col_r;

endmodule

### tb/sv/tb.sv
// Testbench for the bracket balance checker: directed and random texts against a verdict scoreboard.
`timescale 1ns / 1ps

module tb;

  // One expected or observed verdict
  typedef struct packed {
    bbc_pkg::status_t status;
    logic [15:0]      row;
    logic [15:0]      col;
  } verdict_t;

  // Text shapes for the random part
  typedef enum int {
    TXT_CLEAN,
    TXT_UNCLOSED,
    TXT_STRAY,
    TXT_MISMATCH,
    TXT_DEEP,
    TXT_NOISE
  } text_mode_t;

  // Tracks bracket nesting per text and queues the verdict due at each last byte
  class verdict_board;
    bbc_pkg::kind_t   open_kind_st [bbc_pkg::STACK_DEPTH];
    logic [15:0]      open_row_st  [bbc_pkg::STACK_DEPTH];
    logic [15:0]      open_col_st  [bbc_pkg::STACK_DEPTH];
    int               depth;
    logic [15:0]      row_ct;
    logic [15:0]      col_ct;
    bbc_pkg::status_t err_code;
    logic [15:0]      err_row;
    logic [15:0]      err_col;
    verdict_t         due_q[$];
    int               errors;
    int               seen;

    function new();
      errors = 0;
      seen   = 0;
      clear();
    endfunction

    function void clear();
      depth    = 0;
      row_ct   = 16'd1;
      col_ct   = 16'd1;
      err_code = bbc_pkg::ST_OK;
      err_row  = '0;
      err_col  = '0;
    endfunction

    static function bbc_pkg::kind_t kind_opening(logic [7:0] c);
      case (c)
        bbc_pkg::CH_LPAREN:  return bbc_pkg::KIND_PAREN;
        bbc_pkg::CH_LSQUARE: return bbc_pkg::KIND_SQUARE;
        bbc_pkg::CH_LCURLY:  return bbc_pkg::KIND_CURLY;
        default:             return bbc_pkg::KIND_NONE;
      endcase
    endfunction

    static function bbc_pkg::kind_t kind_closing(logic [7:0] c);
      case (c)
        bbc_pkg::CH_RPAREN:  return bbc_pkg::KIND_PAREN;
        bbc_pkg::CH_RSQUARE: return bbc_pkg::KIND_SQUARE;
        bbc_pkg::CH_RCURLY:  return bbc_pkg::KIND_CURLY;
        default:             return bbc_pkg::KIND_NONE;
      endcase
    endfunction

    // Position counters stop at all ones
    static function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Only the first error of a text is kept
    function void latch_err(bbc_pkg::status_t code);
      if (err_code == bbc_pkg::ST_OK) begin
        err_code = code;
        err_row  = row_ct;
        err_col  = col_ct;
      end
    endfunction

    // Accepted text byte: update nesting, position, and queue the verdict on last
    function void note_byte(logic [7:0] c, logic fin);
      bbc_pkg::kind_t ok;
      bbc_pkg::kind_t ck;
      verdict_t       v;
      ok = kind_opening(c);
      ck = kind_closing(c);
      if (err_code == bbc_pkg::ST_OK) begin
        if (ok != bbc_pkg::KIND_NONE) begin
          if (depth >= bbc_pkg::STACK_DEPTH) begin
            latch_err(bbc_pkg::ST_OVERFLOW);
          end else begin
            open_kind_st[depth] = ok;
            open_row_st[depth]  = row_ct;
            open_col_st[depth]  = col_ct;
            depth++;
          end
        end else if (ck != bbc_pkg::KIND_NONE) begin
          if (depth == 0) begin
            latch_err(bbc_pkg::ST_NO_OPEN);
          end else if (open_kind_st[depth-1] != ck) begin
            latch_err(bbc_pkg::ST_MISMATCH);
          end else begin
            depth--;
          end
        end
      end
      if (c == bbc_pkg::CH_NEWLINE) begin
        row_ct = bump(row_ct);
        col_ct = 16'd1;
      end else begin
        col_ct = bump(col_ct);
      end
      if (!fin) return;
      // latched error first, then innermost open bracket, else clean
      if (err_code != bbc_pkg::ST_OK) begin
        v = '{err_code, err_row, err_col};
      end else if (depth != 0) begin
        v = '{bbc_pkg::ST_UNCLOSED, open_row_st[depth-1], open_col_st[depth-1]};
      end else begin
        v = '{bbc_pkg::ST_OK, 16'd0, 16'd0};
      end
      due_q.push_back(v);
      clear();
    endfunction

    task report(string msg);
      if (errors < 30) $display("[%0t] verdict %0d: %s", $realtime, seen, msg);
      errors++;
    endtask

    // Observed verdict against the oldest one due
    task check_verdict(logic [2:0] st, logic [15:0] r, logic [15:0] c);
      verdict_t v;
      seen++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected verdict status=%0d row=%0d col=%0d", st, r, c));
        return;
      end
      v = due_q.pop_front();
      if (st !== v.status)
        report($sformatf("status %0d, want %0d", st, v.status));
      if (r !== v.row)
        report($sformatf("err_row %0d, want %0d", r, v.row));
      if (c !== v.col)
        report($sformatf("err_col %0d, want %0d", c, v.col));
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  bit           calm;
  int           bytes_sent;
  logic [7:0]   text_q[$];
  verdict_board board;

  bbc_in_if  in_ch();
  bbc_out_if out_ch();

  bracket_balance_checker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] opener_char(bbc_pkg::kind_t k);
    case (k)
      bbc_pkg::KIND_PAREN:  return bbc_pkg::CH_LPAREN;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_LSQUARE;
      default:              return bbc_pkg::CH_LCURLY;
    endcase
  endfunction

  function automatic logic [7:0] closer_char(bbc_pkg::kind_t k);
    case (k)
      bbc_pkg::KIND_PAREN:  return bbc_pkg::CH_RPAREN;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_RSQUARE;
      default:              return bbc_pkg::CH_RCURLY;
    endcase
  endfunction

  // Any byte that is neither a bracket nor a newline
  function automatic logic [7:0] filler_byte();
    logic [7:0] r;
    do begin
      r = 8'($urandom_range(255));
    end while (verdict_board::kind_opening(r) != bbc_pkg::KIND_NONE ||
               verdict_board::kind_closing(r) != bbc_pkg::KIND_NONE ||
               r == bbc_pkg::CH_NEWLINE);
    return r;
  endfunction

  // One byte request; waits for the handshake, returns at the next falling edge
  task automatic push_byte(input logic [7:0] c, input logic fin);
    while (!calm && $urandom_range(99) < 23) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.char_code = c;
    in_ch.last      = fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_byte(c, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) push_byte(text_q[i], i == n - 1);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // Random text of the given shape into text_q
  task automatic build_text(input text_mode_t mode);
    bbc_pkg::kind_t open_q[$];
    bbc_pkg::kind_t k;
    int             steps;
    int             bad_at;
    int             r;
    logic [7:0]     marks[7];
    marks = '{bbc_pkg::CH_LPAREN, bbc_pkg::CH_RPAREN, bbc_pkg::CH_LSQUARE,
              bbc_pkg::CH_RSQUARE, bbc_pkg::CH_LCURLY, bbc_pkg::CH_RCURLY,
              bbc_pkg::CH_NEWLINE};
    text_q.delete();
    if (mode == TXT_NOISE) begin
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(3) == 0) text_q.push_back(8'($urandom_range(255)));
        else text_q.push_back(marks[$urandom_range(6)]);
      end
      return;
    end
    if (mode == TXT_DEEP) begin
      // nesting around the stack depth, then a random run of matching closers
      repeat ($urandom_range(60, 70)) begin
        k = bbc_pkg::kind_t'($urandom_range(2));
        open_q.push_back(k);
        text_q.push_back(opener_char(k));
        if ($urandom_range(7) == 0) text_q.push_back(filler_byte());
      end
      while (open_q.size() > 0 && $urandom_range(9) != 0)
        text_q.push_back(closer_char(open_q.pop_back()));
      return;
    end
    steps  = $urandom_range(1, 24);
    bad_at = $urandom_range(0, steps - 1);
    for (int i = 0; i < steps; i++) begin
      r = $urandom_range(9);
      if (i == bad_at && mode == TXT_STRAY) begin
        while (open_q.size() > 0) text_q.push_back(closer_char(open_q.pop_back()));
        text_q.push_back(closer_char(bbc_pkg::kind_t'($urandom_range(2))));
      end else if (i == bad_at && mode == TXT_MISMATCH) begin
        if (open_q.size() == 0) begin
          k = bbc_pkg::kind_t'($urandom_range(2));
          open_q.push_back(k);
          text_q.push_back(opener_char(k));
        end
        k = bbc_pkg::kind_t'((int'(open_q[$]) + $urandom_range(1, 2)) % 3);
        text_q.push_back(closer_char(k));
      end else if (r < 3 && open_q.size() < 16) begin
        k = bbc_pkg::kind_t'($urandom_range(2));
        open_q.push_back(k);
        text_q.push_back(opener_char(k));
      end else if (r < 6 && open_q.size() > 0) begin
        text_q.push_back(closer_char(open_q.pop_back()));
      end else if (r == 6) begin
        text_q.push_back(bbc_pkg::CH_NEWLINE);
      end else begin
        text_q.push_back(filler_byte());
      end
    end
    if (mode == TXT_UNCLOSED) begin
      if (open_q.size() == 0)
        text_q.push_back(opener_char(bbc_pkg::kind_t'($urandom_range(2))));
    end else begin
      while (open_q.size() > 0) text_q.push_back(closer_char(open_q.pop_back()));
    end
  endtask

  // Verdict receiver: random backpressure outside the calm stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = calm || ($urandom_range(99) >= 23);
    end
  end

  // Verdict monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready)
      board.check_verdict(out_ch.status, out_ch.err_row, out_ch.err_col);
  end

  // Main sequence
  initial begin
    int         r;
    int         texts;
    text_mode_t mode;
    board           = new();
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last      = 1'b0;
    rst_n           = 1'b0;
    calm            = 1'b0;
    bytes_sent      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: each verdict kind, errors after an error, newline handling
    send_str("()");
    send_str(")");
    send_str("(]");
    send_str("{\n[");
    send_str("a");
    send_str("[{}]");
    send_str(")(]");
    send_str("\n");
    send_str("x{[}");
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF};
    send_text();

    // stack exactly full, then one opener too many with brackets after it
    text_q.delete();
    repeat (bbc_pkg::STACK_DEPTH) text_q.push_back(bbc_pkg::CH_LCURLY);
    repeat (bbc_pkg::STACK_DEPTH) text_q.push_back(bbc_pkg::CH_RCURLY);
    send_text();
    text_q.delete();
    repeat (bbc_pkg::STACK_DEPTH + 1) text_q.push_back(bbc_pkg::CH_LSQUARE);
    text_q.push_back(bbc_pkg::CH_RPAREN);
    text_q.push_back(bbc_pkg::CH_RSQUARE);
    send_text();

    // random texts, mostly well formed
    texts = 0;
    while (bytes_sent < 650) begin
      calm = (texts >= 15 && texts < 35);
      r = $urandom_range(99);
      if (r < 55)      mode = TXT_CLEAN;
      else if (r < 65) mode = TXT_UNCLOSED;
      else if (r < 73) mode = TXT_STRAY;
      else if (r < 82) mode = TXT_MISMATCH;
      else if (r < 86) mode = TXT_DEEP;
      else             mode = TXT_NOISE;
      build_text(mode);
      send_text();
      texts++;
    end
    calm = 1'b0;

    // drain
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
